>>> sv/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// shared types and codes of the binary min-heap queue
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int unsigned KEY_BITS  = 32;
  localparam int unsigned POS_BITS  = 6;
  localparam int unsigned WORD_BITS = 32;   // payload bits carried on the channels
  localparam int unsigned FILL_BITS = 7;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_REDUCE  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RD_ROOT,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_RDR,
    S_DN_CMP,
    S_HOME,
    S_RD_MIN,
    S_MIN_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t                        op;
    logic signed [KEY_BITS-1:0] key_in;
    logic [WORD_BITS-1:0]       payload_in;
    logic [POS_BITS-1:0]        position;
  } cmd_word_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] min_key;
    logic [WORD_BITS-1:0]       min_payload;
    logic [FILL_BITS-1:0]       fill_count;
    logic                       is_empty;
    status_t                    status;
  } res_word_t;

endpackage

>>> sv/bmhq_if.sv
// ----------------------------------------------------------------------------
// bmhq_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface bmhq_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// single-port generic ram with registered read
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> sv/bmhq_front.sv
// ----------------------------------------------------------------------------
// bmhq_front
// accepts command words and classifies them into a two-entry queue
// ----------------------------------------------------------------------------
module bmhq_front import bmhq_pkg::*; #(
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_op,
  input  logic [KEY_BITS-1:0]     in_key,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  input  logic [POS_BITS-1:0]     in_position,
  output logic                    cmd_valid,
  input  logic                    cmd_ready,
  output op_t                     cmd_op,
  output logic [KEY_BITS-1:0]     cmd_key,
  output logic [PAYLOAD_BITS-1:0] cmd_payload,
  output logic [POS_BITS-1:0]     cmd_position
);
  localparam int unsigned W = 2 + KEY_BITS + PAYLOAD_BITS + POS_BITS;

  logic [W-1:0] q [2];
  logic         rd_ptr, wr_ptr;
  logic [1:0]   count;
  logic         push, pop;
  logic [1:0]   op_cls;

  // unused codes fold into one class
  always_comb begin
    case (in_op)
      OP_INSERT:  op_cls = OP_INSERT;
      OP_EXTRACT: op_cls = OP_EXTRACT;
      OP_REDUCE:  op_cls = OP_REDUCE;
      default:    op_cls = OP_NONE;
    endcase
  end

  assign in_ready  = count != 2'd2;
  assign cmd_valid = count != 2'd0;
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  assign cmd_op       = op_t'(q[rd_ptr][W-1 -: 2]);
  assign cmd_key      = q[rd_ptr][W-3 -: KEY_BITS];
  assign cmd_payload  = q[rd_ptr][POS_BITS +: PAYLOAD_BITS];
  assign cmd_position = q[rd_ptr][POS_BITS-1:0];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= {op_cls, in_key, in_payload, in_position};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> sv/bmhq_back.sv
// ----------------------------------------------------------------------------
// bmhq_back
// heap engine: sift up and sift down over one memory, result register
// ----------------------------------------------------------------------------
module bmhq_back import bmhq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH   = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  op_t                     cmd_op,
  input  logic [KEY_BITS-1:0]     cmd_key,
  input  logic [PAYLOAD_BITS-1:0] cmd_payload,
  input  logic [POS_BITS-1:0]     cmd_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [KEY_BITS-1:0]     min_key,
  output logic [PAYLOAD_BITS-1:0] min_payload,
  output logic [6:0]              fill_count,
  output logic                    is_empty,
  output logic [1:0]              status
);
  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned FW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned EW = KEY_BITS + PAYLOAD_BITS;
  localparam logic [FW-1:0] FULL = FW'(HEAP_DEPTH);

  state_t state, state_next;

  logic [FW-1:0]           fill;
  logic [AW:0]             idx;      // current node, one spare bit for child math
  logic [EW-1:0]           cur;      // entry being sifted
  logic [EW-1:0]           lchild;
  op_t                     op;
  logic [KEY_BITS-1:0]     key;
  logic [PAYLOAD_BITS-1:0] pay;
  logic [POS_BITS-1:0]     pos;
  status_t                 st;
  logic [KEY_BITS-1:0]     root_key;
  logic [PAYLOAD_BITS-1:0] root_pay;

  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;

  bmhq_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [AW:0] parent, left, right;
  assign parent = (idx - 1'b1) >> 1;
  assign left   = {idx[AW-1:0], 1'b1};
  assign right  = left + 1'b1;

  logic signed [KEY_BITS-1:0] cur_k, rd_k, l_k;
  assign cur_k = cur[EW-1 -: KEY_BITS];
  assign rd_k  = rdata[EW-1 -: KEY_BITS];
  assign l_k   = lchild[EW-1 -: KEY_BITS];

  logic l_ok, r_ok, l_less, r_best;
  assign l_ok   = 32'(left) < 32'(fill);
  assign r_ok   = 32'(right) < 32'(fill);
  assign l_less = l_ok && (l_k < cur_k);
  assign r_best = r_ok && (rd_k < (l_less ? l_k : cur_k));

  logic pos_ok;
  assign pos_ok = 32'(pos) < 32'(fill);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (cmd_valid) state_next = S_START;
      S_START: begin
        case (op)
          OP_INSERT:  state_next = (fill == FULL) ? S_OUT :
                                   (fill == '0) ? S_RD_MIN : S_UP_RD;
          OP_EXTRACT: state_next = (fill == '0) ? S_OUT :
                                   (fill == FW'(1)) ? S_OUT : S_RD_ROOT;
          OP_REDUCE:  state_next = pos_ok ? S_RD_ROOT : S_OUT;
          default:    state_next = S_OUT;
        endcase
      end
      S_RD_ROOT: begin
        if (op == OP_EXTRACT) begin
          state_next = S_DN_RD;
        end else begin
          state_next = (rd_k > cur_k) ? ((idx == '0) ? S_RD_MIN : S_UP_RD) : S_OUT;
        end
      end
      S_UP_RD: state_next = S_UP_CMP;
      S_UP_CMP: begin
        if (rd_k > cur_k) state_next = (parent == '0) ? S_HOME : S_UP_RD;
        else state_next = S_RD_MIN;
      end
      S_DN_RD: state_next = l_ok ? S_DN_RDR : S_RD_MIN;
      S_DN_RDR: state_next = S_DN_CMP;
      S_DN_CMP: state_next = (l_less || r_best) ? S_DN_RD : S_RD_MIN;
      S_HOME: state_next = S_RD_MIN;
      S_RD_MIN: state_next = S_MIN_WAIT;
      S_MIN_WAIT: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory port; the sifted entry is written home when the walk ends
  always_comb begin
    we    = 1'b0;
    addr  = idx[AW-1:0];
    wdata = cur;
    case (state)
      S_START: begin
        if (op == OP_INSERT) begin
          addr = AW'(fill);
          we   = fill != FULL;
          wdata = {key, pay};
        end else if (op == OP_EXTRACT) begin
          addr = AW'(fill - 1'b1);
        end else begin
          addr = AW'(pos);
        end
      end
      S_RD_ROOT: begin
        if (op == OP_EXTRACT) begin
          addr = '0;
          we   = 1'b1;
          wdata = rdata;
        end else begin
          addr  = idx[AW-1:0];
          we    = rd_k > cur_k;
          wdata = {cur_k, rdata[PAYLOAD_BITS-1:0]};
        end
      end
      S_UP_RD:  addr = parent[AW-1:0];
      S_UP_CMP: begin
        addr  = idx[AW-1:0];
        we    = 1'b1;
        wdata = (rd_k > cur_k) ? rdata : cur;
      end
      S_DN_RD: begin
        if (l_ok) addr = left[AW-1:0];
        else we = 1'b1;
      end
      S_DN_RDR: addr = right[AW-1:0];
      S_DN_CMP: begin
        addr = idx[AW-1:0];
        we   = 1'b1;
        wdata = r_best ? rdata : (l_less ? lchild : cur);
      end
      S_HOME:   we = 1'b1;
      S_RD_MIN: addr = '0;
      default:  addr = idx[AW-1:0];
    endcase
  end

  assign cmd_ready = state == S_IDLE;
  assign out_valid = state == S_OUT;

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op  <= cmd_op;
        key <= cmd_key;
        pay <= cmd_payload;
        pos <= cmd_position;
        st  <= ST_DONE;
      end
      S_START: begin
        case (op)
          OP_INSERT: begin
            cur <= {key, pay};
            idx <= (AW+1)'(fill);
            if (fill == FULL) st <= ST_FULL;
          end
          OP_EXTRACT: begin
            idx <= '0;
            if (fill == '0) st <= ST_EMPTY;
          end
          OP_REDUCE: begin
            idx <= (AW+1)'(pos);
            cur <= {key, pay};
            if (!pos_ok) st <= ST_IGNORED;
          end
          default: st <= ST_IGNORED;
        endcase
      end
      S_RD_ROOT: begin
        if (op == OP_EXTRACT) begin
          cur <= rdata;
        end else if (!(rd_k > cur_k)) begin
          st <= ST_IGNORED;
        end else begin
          cur <= {cur_k, rdata[PAYLOAD_BITS-1:0]};
        end
      end
      S_UP_CMP: begin
        if (rd_k > cur_k) begin
          idx <= parent;
        end
      end
      S_DN_RDR: lchild <= rdata;
      S_DN_CMP: if (l_less || r_best) idx <= r_best ? right : left;
      S_MIN_WAIT: begin
        root_key <= rd_k;
        root_pay <= rdata[PAYLOAD_BITS-1:0];
      end
      default: ;
    endcase
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (state == S_START) begin
        if (op == OP_INSERT && fill != FULL) fill <= fill + 1'b1;
        if (op == OP_EXTRACT && fill != '0) fill <= fill - 1'b1;
      end
    end
  end

  // root register is stale once the heap runs empty
  assign min_key     = (fill == '0) ? '0 : root_key;
  assign min_payload = (fill == '0) ? '0 : root_pay;
  assign fill_count  = 7'(fill);
  assign is_empty    = fill == '0;
  assign status      = st;
endmodule

>>> sv/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// min-heap priority queue of signed keys with payloads
// steps: sift up reads the parent and compares per level (S_UP_RD, S_UP_CMP);
// sift down reads both children (S_DN_RD, S_DN_RDR, S_DN_CMP), at most 5 levels at depth 64
// flow: one command at a time; the engine takes the next once the result word is accepted
// reset: synchronous; heap empties at once, stored entries are not cleared
// ----------------------------------------------------------------------------
module binary_min_heap_queue import bmhq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH   = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  bmhq_if.sink   in_ch,
  bmhq_if.source out_ch
);
  logic                    cmd_valid, cmd_ready;
  op_t                     cmd_op;
  logic [KEY_BITS-1:0]     cmd_key;
  logic [PAYLOAD_BITS-1:0] cmd_payload;
  logic [POS_BITS-1:0]     cmd_position;
  logic [PAYLOAD_BITS-1:0] in_payload;
  logic [KEY_BITS-1:0]     min_key;
  logic [PAYLOAD_BITS-1:0] min_payload;
  logic [FILL_BITS-1:0]    fill_count;
  logic                    is_empty;
  logic [1:0]              status;

  assign in_payload  = PAYLOAD_BITS'(in_ch.data.payload_in);
  assign out_ch.data = {min_key, WORD_BITS'(min_payload), fill_count, is_empty, status};

  bmhq_front #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.data.op), .in_key(in_ch.data.key_in),
    .in_payload(in_payload),
    .in_position(in_ch.data.position),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_op(cmd_op),
    .cmd_key(cmd_key), .cmd_payload(cmd_payload), .cmd_position(cmd_position)
  );

  bmhq_back #(.HEAP_DEPTH(HEAP_DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_op(cmd_op),
    .cmd_key(cmd_key), .cmd_payload(cmd_payload), .cmd_position(cmd_position),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .min_key(min_key), .min_payload(min_payload),
    .fill_count(fill_count), .is_empty(is_empty),
    .status(status)
  );
endmodule
